### rtl/mcst_pkg.sv
// mcst_pkg: shared types, constants and codes for the soft timer table
// no dependencies
`timescale 1ns / 1ps
package mcst_pkg;
   localparam int unsigned ENTRIES_DEF = 16;
   localparam logic [31:0] HANDLE_BASE = 32'h0000_EEDF;
   localparam logic [19:0] MIN_BASE = 20'd10;
   localparam logic [19:0] BASE_RESET = 20'd1000;

   typedef enum logic [2:0] {
      OP_TICK = 3'd0, OP_REGISTER = 3'd1, OP_UNREGISTER = 3'd2,
      OP_START = 3'd3, OP_STOP = 3'd4, OP_RESTART = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_NOT_FOUND = 2'd1, ST_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_DIV, S_SCAN, S_APPLY, S_OUT
   } state_type;

   // command broadcast to every cell
   typedef struct packed {
      logic        tick;
      logic        alloc;
      logic        clear;
      logic        stop;
      logic        start;
      logic [31:0] handle;
      logic [31:0] count;
      logic        periodic;
   } cmd_type;

   // search token passed along the chain
   typedef struct packed {
      logic        found;
      logic        free;
      logic        fire;
      logic [31:0] handle;
   } tok_type;
endpackage

### rtl/mcst_if.sv
// mcst_if: valid/ready channel interface with a generic payload
// depends on nothing
`timescale 1ns / 1ps
interface mcst_if #(parameter int unsigned W = 8);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### rtl/mcst_div.sv
// mcst_div: radix-2 restoring divider, one quotient bit per cycle
// depends on mcst_pkg
`timescale 1ns / 1ps
module mcst_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [33:0] dividend,
   input  logic [20:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   import mcst_pkg::*;
   logic [33:0] q_ff, q_in;
   logic [21:0] r_ff, r_in;
   logic [5:0]  n_ff, n_in;
   logic        busy_ff, busy_in;
   logic [21:0] trial;

   // shift one dividend bit in, subtract when it fits
   always_comb begin
      q_in = q_ff; r_in = r_ff; n_in = n_ff; busy_in = busy_ff;
      trial = {r_ff[20:0], q_ff[33]} - {1'b0, divisor};
      if (start) begin
         q_in = dividend; r_in = '0; n_in = 6'd34; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[21]) begin
            r_in = trial;
         end else begin
            r_in = {r_ff[20:0], q_ff[33]};
         end
         q_in = {q_ff[32:0], ~trial[21]};
         n_in = n_ff - 6'd1;
         if (n_ff == 6'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; n_ff <= n_in;
      if (reset) busy_ff <= 1'b0; else busy_ff <= busy_in;
   end

   assign done = busy_ff && (n_ff == 6'd1);
   // quotient fits 32 bits since divisor >= 20
   assign quotient = q_in[31:0];
endmodule

### rtl/mcst_cell.sv
// mcst_cell: one timer entry; passes the search token to its neighbor
// depends on mcst_pkg
`timescale 1ns / 1ps
module mcst_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  mcst_pkg::cmd_type   cmd,
   input  mcst_pkg::tok_type   tok_i,
   output mcst_pkg::tok_type   tok_o
);
   import mcst_pkg::*;
   logic [31:0] handle_ff, handle_in, count_ff, count_in, reload_ff, reload_in;
   logic        per_ff, per_in, run_ff, run_in;
   logic [31:0] dec;
   logic        live, match, is_free, zero;

   always_comb begin
      live    = (handle_ff != '0);
      match   = live && (cmd.handle != '0) && (handle_ff == cmd.handle);
      is_free = !live;
      dec     = (count_ff != '0) ? count_ff - 32'd1 : count_ff;
      zero    = live && run_ff && (dec == '0);
      tok_o   = tok_i;
      handle_in = handle_ff; count_in = count_ff; reload_in = reload_ff;
      per_in = per_ff; run_in = run_ff;
      if (cmd.tick) begin
         if (live && run_ff) count_in = dec;
         if (zero && !tok_i.fire) begin
            tok_o.fire = 1'b1; tok_o.handle = handle_ff;
            if (per_ff) count_in = reload_ff; else run_in = 1'b0;
         end
      end else if (cmd.alloc) begin
         if (is_free && !tok_i.free) begin
            tok_o.free = 1'b1;
            handle_in = cmd.handle; count_in = cmd.count; reload_in = cmd.count;
            per_in = cmd.periodic; run_in = 1'b0;
         end
      end else if (match && !tok_i.found) begin
         tok_o.found = 1'b1;
         if (cmd.clear) begin
            handle_in = '0; count_in = '0; reload_in = '0; per_in = 1'b0; run_in = 1'b0;
         end else if (cmd.stop) begin
            run_in = 1'b0;
         end else if (cmd.start) begin
            count_in = reload_ff; run_in = 1'b1;
         end
      end
   end

   // entry storage, updated only on the apply step
   always_ff @(posedge clock) begin
      if (reset) begin
         handle_ff <= '0; count_ff <= '0; reload_ff <= '0;
         per_ff <= 1'b0; run_ff <= 1'b0;
      end else if (step) begin
         handle_ff <= handle_in; count_ff <= count_in; reload_ff <= reload_in;
         per_ff <= per_in; run_ff <= run_in;
      end
   end
endmodule

### rtl/mcst_chain.sv
// mcst_chain: row of timer cells chained through a combinational search token
// depends on mcst_pkg, mcst_cell
`timescale 1ns / 1ps
module mcst_chain #(
   parameter int unsigned ENTRIES = mcst_pkg::ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  mcst_pkg::cmd_type cmd,
   output mcst_pkg::tok_type tok_out
);
   import mcst_pkg::*;
   tok_type tok [ENTRIES+1];

   assign tok[0] = '0;
   // cells chained through the token; each commits on the common apply strobe
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      mcst_cell u_cell (
         .clock(clock), .reset(reset), .step(step), .cmd(cmd),
         .tok_i(tok[i]), .tok_o(tok[i+1])
      );
   end
   assign tok_out = tok[ENTRIES];
endmodule

### rtl/multi_channel_soft_timer_table.sv
// multi_channel_soft_timer_table: top level, sequencer, divider and cell row
// depends on mcst_pkg, mcst_if, mcst_div, mcst_chain
//
//  channel | dir | payload
//  req     | in  | operation, delay_us, periodic, handle
//  rsp     | out | status, handle_out, fired
//  csr     | in  | time_base_us write
//
// register passes through a load state and the divider, which shifts in all 34 dividend bits
// other items go straight to the apply state; the result is registered there and is valid in the output state
// reset clears all entries, the serial and sets the time base to 1000
// the item is held in the output register until rsp is taken; req waits meanwhile
`timescale 1ns / 1ps
module multi_channel_soft_timer_table #(
   parameter int unsigned ENTRIES = mcst_pkg::ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   mcst_if.sink        req,
   mcst_if.source      rsp,
   input  logic        csr_wr_en,
   input  logic [19:0] csr_wr_data
);
   import mcst_pkg::*;
   state_type   state_ff, state_in;
   logic [19:0] base_ff;
   logic [2:0]  op_ff;
   logic [31:0] delay_ff, handle_ff, serial_ff, serial_in, cnt_ff;
   logic        per_ff;
   logic [34:0] rsp_ff;
   cmd_type     cmd;
   tok_type     tok;
   logic [19:0] base;
   logic [32:0] d;
   logic        div_done, step;
   logic [31:0] quot, nh1, nh;

   assign base = (base_ff < MIN_BASE) ? MIN_BASE : base_ff;
   assign d = ({1'b0, delay_ff} < {13'd0, base}) ? {13'd0, base} : {1'b0, delay_ff};

   // divider starts once the item is in the holding registers
   mcst_div u_div (
      .clock(clock), .reset(reset), .start(state_ff == S_SCAN),
      .dividend({d, 1'b0} + {14'd0, base}), .divisor({base, 1'b0}),
      .done(div_done), .quotient(quot)
   );

   // new handle, skipping zero
   assign nh1 = HANDLE_BASE + serial_ff + 32'd1;
   assign nh  = (nh1 == '0) ? nh1 + 32'd1 : nh1;

   always_comb begin
      cmd = '0;
      cmd.tick  = (op_ff == OP_TICK);
      cmd.alloc = (op_ff == OP_REGISTER);
      cmd.clear = (op_ff == OP_UNREGISTER);
      cmd.stop  = (op_ff == OP_STOP);
      cmd.start = (op_ff == OP_START) || (op_ff == OP_RESTART);
      cmd.handle = cmd.alloc ? nh : handle_ff;
      cmd.count = cnt_ff;
      cmd.periodic = per_ff;
   end

   mcst_chain #(.ENTRIES(ENTRIES)) u_chain (
      .clock(clock), .reset(reset), .step(step), .cmd(cmd), .tok_out(tok)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req.valid) state_in = (req.data[2:0] == OP_REGISTER) ? S_SCAN : S_APPLY;
         S_SCAN:  state_in = S_DIV;
         S_DIV:   if (div_done) state_in = S_APPLY;
         S_APPLY: state_in = S_OUT;
         S_OUT:   if (rsp.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      step = (state_ff == S_APPLY) && (op_ff <= OP_RESTART);
      serial_in = serial_ff;
      if (step && cmd.alloc && tok.free) serial_in = nh - HANDLE_BASE;
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; base_ff <= BASE_RESET; serial_ff <= '0;
      end else begin
         state_ff <= state_in; serial_ff <= serial_in;
         if (csr_wr_en) base_ff <= csr_wr_data;
      end
      if (state_ff == S_IDLE && req.valid) begin
         op_ff <= req.data[2:0]; delay_ff <= req.data[34:3];
         per_ff <= req.data[35]; handle_ff <= req.data[67:36];
      end
      if (div_done) cnt_ff <= quot;
      // result register: {fired, handle_out, status}
      if (state_ff == S_APPLY) begin
         rsp_ff <= '0;
         if (op_ff == OP_TICK) begin
            rsp_ff <= {tok.fire, tok.fire ? tok.handle : 32'd0, ST_OK};
         end else if (op_ff == OP_REGISTER) begin
            rsp_ff <= tok.free ? {1'b0, nh, ST_OK} : {1'b0, 32'd0, ST_FULL};
         end else if (op_ff <= OP_RESTART) begin
            rsp_ff <= {1'b0, 32'd0, tok.found ? ST_OK : ST_NOT_FOUND};
         end
      end
   end
endmodule
